// File: rtl/sta_lta_quake_trigger_unit_assert.svh
// Assertion macros for the quake trigger unit.
`ifndef STA_LTA_QUAKE_TRIGGER_UNIT_ASSERT_SVH
`define STA_LTA_QUAKE_TRIGGER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SLQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/slq_pkg.sv
// ---------------------------------------------------------------------------
// slq_pkg
// Shared types and constants of the quake trigger unit.
// ---------------------------------------------------------------------------
package slq_pkg;
    localparam int AXIS_W  = 14;
    localparam int MAG_W   = 15;
    localparam int RATIO_W = 19;
    localparam int PCT_W   = 7;
    localparam int LEN_W   = 11;
    localparam int THR_W   = 10;
    localparam int ADDR_W  = 5;

    localparam logic [ADDR_W-1:0] REG_BIAS_X    = 5'd0;
    localparam logic [ADDR_W-1:0] REG_BIAS_Y    = 5'd4;
    localparam logic [ADDR_W-1:0] REG_BIAS_Z    = 5'd8;
    localparam logic [ADDR_W-1:0] REG_SHORT_LEN = 5'd12;
    localparam logic [ADDR_W-1:0] REG_LONG_LEN  = 5'd16;
    localparam logic [ADDR_W-1:0] REG_ON_THR    = 5'd20;
    localparam logic [ADDR_W-1:0] REG_OFF_THR   = 5'd24;
    localparam logic [ADDR_W-1:0] REG_MID_PCT   = 5'd28;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SQRT, ST_WRITE, ST_SUM, ST_DRAIN,
        ST_DIV_S, ST_DIV_L, ST_DIV_Z, ST_DIV_R, ST_DIV_ZR, ST_DONE, ST_OUT
    } slq_state_t;

    // divider control
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } slq_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quo;
    } slq_div_rsp_t;
endpackage

// File: rtl/slq_if.sv
// ---------------------------------------------------------------------------
// slq_in_if / slq_out_if
// Valid/ready channels of the quake trigger unit.
// ---------------------------------------------------------------------------
interface slq_in_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] accel_x;
    logic signed [13:0] accel_y;
    logic signed [13:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface slq_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] short_avg;
    logic [14:0] long_avg;
    logic [18:0] trigger_ratio;
    logic        alert_active;
    logic [6:0]  quake_percent;
    logic [6:0]  p_wave_percent;
    logic [6:0]  s_wave_percent;
    modport source (output valid, short_avg, long_avg, trigger_ratio, alert_active,
                    quake_percent, p_wave_percent, s_wave_percent, input ready);
    modport sink (input valid, short_avg, long_avg, trigger_ratio, alert_active,
                  quake_percent, p_wave_percent, s_wave_percent, output ready);
endinterface

// File: rtl/slq_divider.sv
// ---------------------------------------------------------------------------
// slq_divider
// Restoring divider, one quotient bit per cycle, shared by all quotients.
// ---------------------------------------------------------------------------
module slq_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slq_pkg::slq_div_req_t req,
    output slq_pkg::slq_div_rsp_t rsp
);
    import slq_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// File: rtl/sta_lta_quake_trigger_unit.sv
// ---------------------------------------------------------------------------
// sta_lta_quake_trigger_unit
// STA/LTA seismic trigger over a stream of 3-axis accelerometer words.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch takes one sample word (accel_x/y/z); out_ch returns one result word
//   per sample. The user writes registers through the APB port only while
//   idle; the block itself does not enforce it. After reset a clearing pass
//   zeroes both rings, with in_ch.ready low; register writes are taken
//   meanwhile. Per sample: a bit-serial square root, 1 ring write, long_len
//   ring reads (one port, then a pipeline drain), then five divisions on one
//   shared divider and a load of the output register, long_len being the
//   effective long window. A new sample is taken only once the last one has
//   gone through all of these steps.
//   The result word is held in an output register until taken; in_ch.ready
//   rises again once it is taken, so a stalled receiver stalls the input.
// ---------------------------------------------------------------------------
module sta_lta_quake_trigger_unit #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    slq_in_if.sink                    in_ch,
    slq_out_if.source                 out_ch,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [slq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import slq_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    // configuration registers
    logic [AXIS_W-1:0] bias_x_reg, bias_y_reg, bias_z_reg;
    logic [LEN_W-1:0]  short_len_reg, long_len_reg;
    logic [THR_W-1:0]  on_thr_reg, off_thr_reg;
    logic [PCT_W-1:0]  mid_pct_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg    <= '0;
            bias_y_reg    <= '0;
            bias_z_reg    <= '0;
            short_len_reg <= 11'd10;
            long_len_reg  <= 11'd100;
            on_thr_reg    <= 10'd15;
            off_thr_reg   <= 10'd10;
            mid_pct_reg   <= 7'd75;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                REG_BIAS_X:    bias_x_reg    <= pwdata[AXIS_W-1:0];
                REG_BIAS_Y:    bias_y_reg    <= pwdata[AXIS_W-1:0];
                REG_BIAS_Z:    bias_z_reg    <= pwdata[AXIS_W-1:0];
                REG_SHORT_LEN: short_len_reg <= pwdata[LEN_W-1:0];
                REG_LONG_LEN:  long_len_reg  <= pwdata[LEN_W-1:0];
                REG_ON_THR:    on_thr_reg    <= pwdata[THR_W-1:0];
                REG_OFF_THR:   off_thr_reg   <= pwdata[THR_W-1:0];
                REG_MID_PCT:   mid_pct_reg   <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_BIAS_X:    prdata = {18'd0, bias_x_reg};
            REG_BIAS_Y:    prdata = {18'd0, bias_y_reg};
            REG_BIAS_Z:    prdata = {18'd0, bias_z_reg};
            REG_SHORT_LEN: prdata = {21'd0, short_len_reg};
            REG_LONG_LEN:  prdata = {21'd0, long_len_reg};
            REG_ON_THR:    prdata = {22'd0, on_thr_reg};
            REG_OFF_THR:   prdata = {22'd0, off_thr_reg};
            REG_MID_PCT:   prdata = {25'd0, mid_pct_reg};
            default:       prdata = '0;
        endcase
    end

    // window lengths: zero as one, saturate at the ring depth, short <= long
    logic [CNT_W-1:0] nl, ns_raw, ns;
    always_comb
    begin
        if (long_len_reg == '0)
            nl = CNT_W'(1);
        else if ({21'd0, long_len_reg} > 32'(RING_DEPTH))
            nl = CNT_W'(RING_DEPTH);
        else
            nl = CNT_W'(long_len_reg);
        if (short_len_reg == '0)
            ns_raw = CNT_W'(1);
        else if ({21'd0, short_len_reg} > 32'(RING_DEPTH))
            ns_raw = CNT_W'(RING_DEPTH);
        else
            ns_raw = CNT_W'(short_len_reg);
        ns = (ns_raw > nl) ? nl : ns_raw;
    end

    // state
    slq_state_t state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             alert_reg, alert_next;
    logic [RATIO_W-1:0] peak_reg, peak_next;

    // datapath registers
    logic [29:0] sq_v_reg, sq_v_next;
    logic [29:0] sq_res_reg, sq_res_next;
    logic [29:0] sq_bit_reg, sq_bit_next;
    logic [MAG_W-1:0] az_reg, az_next;
    logic [24:0] ssum_reg, ssum_next, lsum_reg, lsum_next, zsum_reg, zsum_next;
    logic [MAG_W-1:0] sta_reg, sta_next, lta_reg, lta_next, zsta_reg, zsta_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [PTR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [1:0]       rv_reg;      // read pipeline valid
    logic             rs0_reg;     // read pipeline in short window
    logic [1:0]       rsp_reg;

    // rings, one write and one read port each, registered read
    logic [MAG_W-1:0] mag_ring [RING_DEPTH];
    logic [MAG_W-1:0] az_ring [RING_DEPTH];
    logic [MAG_W-1:0] mag_rd_reg, az_rd_reg;
    logic             ring_we;
    logic [PTR_W-1:0] ring_wa;
    logic [MAG_W-1:0] ring_wm, ring_wz;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            mag_ring[ring_wa] <= ring_wm;
            az_ring[ring_wa]  <= ring_wz;
        end
        mag_rd_reg <= mag_ring[rd_addr_reg];
        az_rd_reg  <= az_ring[rd_addr_reg];
    end

    // shared divider
    slq_div_req_t div_req;
    slq_div_rsp_t div_rsp;
    slq_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // output register
    logic        ov_reg;
    logic [14:0] o_sta_reg, o_lta_reg;
    logic [18:0] o_ratio_reg;
    logic        o_alert_reg;
    logic [6:0]  o_q_reg, o_p_reg, o_s_reg;

    // bias subtraction and absolute values
    logic signed [AXIS_W:0] dx, dy, dz;
    logic [AXIS_W:0] ax, ay, az;
    logic [29:0] sumsq;
    assign dx = $signed({in_ch.accel_x[AXIS_W-1], in_ch.accel_x})
                - $signed({bias_x_reg[AXIS_W-1], bias_x_reg});
    assign dy = $signed({in_ch.accel_y[AXIS_W-1], in_ch.accel_y})
                - $signed({bias_y_reg[AXIS_W-1], bias_y_reg});
    assign dz = $signed({in_ch.accel_z[AXIS_W-1], in_ch.accel_z})
                - $signed({bias_z_reg[AXIS_W-1], bias_z_reg});
    assign ax = dx[AXIS_W] ? $unsigned(-dx) : $unsigned(dx);
    assign ay = dy[AXIS_W] ? $unsigned(-dy) : $unsigned(dy);
    assign az = dz[AXIS_W] ? $unsigned(-dz) : $unsigned(dz);
    assign sumsq = 30'(ax) * 30'(ax) + 30'(ay) * 30'(ay) + 30'(az) * 30'(az);

    logic [29:0] sq_trial;
    assign sq_trial = sq_res_reg + sq_bit_reg;

    logic [31:0] zr_w;
    logic [PCT_W-1:0] sp_w;
    assign zr_w = (sta_reg == '0) ? 32'd0 : div_rsp.quo;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (cnt_reg == CNT_W'(RING_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (in_ch.valid) state_next = ST_SQRT;
            ST_SQRT:   if (sq_bit_reg == 30'd1) state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_SUM;
            ST_SUM:    if (cnt_reg == nl - CNT_W'(1)) state_next = ST_DRAIN;
            ST_DRAIN:  if (rv_reg == 2'b00) state_next = ST_DIV_S;
            ST_DIV_S:  if (div_rsp.done) state_next = ST_DIV_L;
            ST_DIV_L:  if (div_rsp.done) state_next = ST_DIV_Z;
            ST_DIV_Z:  if (div_rsp.done) state_next = ST_DIV_R;
            ST_DIV_R:  if (div_rsp.done) state_next = ST_DIV_ZR;
            ST_DIV_ZR: if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:   state_next = ST_OUT;
            ST_OUT:    if (!ov_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb
    begin
        wp_next      = wp_reg;
        cnt_next     = cnt_reg;
        alert_next   = alert_reg;
        peak_next    = peak_reg;
        sq_v_next    = sq_v_reg;
        sq_res_next  = sq_res_reg;
        sq_bit_next  = sq_bit_reg;
        az_next      = az_reg;
        ssum_next    = ssum_reg;
        lsum_next    = lsum_reg;
        zsum_next    = zsum_reg;
        sta_next     = sta_reg;
        lta_next     = lta_reg;
        zsta_next    = zsta_reg;
        ratio_next   = ratio_reg;
        rd_addr_next = rd_addr_reg;
        ring_we      = 1'b0;
        ring_wa      = wp_reg;
        ring_wm      = sq_res_reg[MAG_W-1:0];
        ring_wz      = az_reg;
        div_req      = '0;
        sp_w         = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ring_we  = 1'b1;
                ring_wa  = cnt_reg[PTR_W-1:0];
                ring_wm  = '0;
                ring_wz  = '0;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                sq_v_next   = sumsq;
                sq_res_next = '0;
                sq_bit_next = 30'h1000_0000;
                az_next     = MAG_W'(az);
            end
            ST_SQRT:
            begin
                // one root bit per cycle
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_next   = sq_v_reg - sq_trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
            end
            ST_WRITE:
            begin
                ring_we      = 1'b1;
                wp_next      = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                rd_addr_next = wp_reg;
                cnt_next     = '0;
                ssum_next    = '0;
                lsum_next    = '0;
                zsum_next    = '0;
            end
            ST_SUM:
            begin
                rd_addr_next = (rd_addr_reg == '0) ? PTR_W'(RING_DEPTH - 1)
                                                   : rd_addr_reg - PTR_W'(1);
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            ST_DIV_S:
            begin
                div_req.start = !div_rsp.busy && !div_rsp.done;
                div_req.num   = 32'(ssum_reg);
                div_req.den   = 32'(ns);
                if (div_rsp.done) sta_next = div_rsp.quo[MAG_W-1:0];
            end
            ST_DIV_L:
            begin
                div_req.start = !div_rsp.busy && !div_rsp.done;
                div_req.num   = 32'(lsum_reg);
                div_req.den   = 32'(nl);
                if (div_rsp.done) lta_next = div_rsp.quo[MAG_W-1:0];
            end
            ST_DIV_Z:
            begin
                div_req.start = !div_rsp.busy && !div_rsp.done;
                div_req.num   = 32'(zsum_reg);
                div_req.den   = 32'(ns);
                if (div_rsp.done) zsta_next = div_rsp.quo[MAG_W-1:0];
            end
            ST_DIV_R:
            begin
                div_req.start = !div_rsp.busy && !div_rsp.done;
                div_req.num   = 32'(sta_reg) * 32'd10;
                div_req.den   = (lta_reg == '0) ? 32'd1 : 32'(lta_reg);
                if (div_rsp.done)
                    ratio_next = (lta_reg == '0) ? '0 : div_rsp.quo[RATIO_W-1:0];
            end
            ST_DIV_ZR:
            begin
                div_req.start = !div_rsp.busy && !div_rsp.done;
                div_req.num   = 32'(zsta_reg) * 32'd100;
                div_req.den   = (sta_reg == '0) ? 32'd1 : 32'(sta_reg);
                if (div_rsp.done)
                begin
                    // hysteresis and peak tracking
                    if (alert_reg)
                    begin
                        if (ratio_reg < RATIO_W'(off_thr_reg))
                        begin
                            alert_next = 1'b0;
                            peak_next  = '0;
                        end
                        else if (ratio_reg > peak_reg)
                            peak_next = ratio_reg;
                    end
                    else if (ratio_reg > RATIO_W'(on_thr_reg))
                    begin
                        alert_next = 1'b1;
                        peak_next  = ratio_reg;
                    end
                end
            end
            default: ;
        endcase
        if (zr_w < 32'd33)
            sp_w = 7'd100;
        else if (zr_w < 32'd50)
            sp_w = 7'd50;
        else
            sp_w = 7'd0;
        // accumulate returning ring words
        if (rv_reg[0])
        begin
            lsum_next = lsum_reg + 25'(mag_rd_reg);
            if (rs0_reg)
            begin
                ssum_next = ssum_reg + 25'(mag_rd_reg);
                zsum_next = zsum_reg + 25'(az_rd_reg);
            end
        end
    end

    // read pipeline tags: address issued, then data registered and used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg  <= '0;
            rs0_reg <= 1'b0;
        end
        else
        begin
            rv_reg  <= {rv_reg[0], state_reg == ST_SUM};
            rs0_reg <= cnt_reg < ns;
        end
    end
    assign rsp_reg = rv_reg;

    logic [PCT_W-1:0] sp_hold_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wp_reg    <= '0;
            cnt_reg   <= '0;
            alert_reg <= 1'b0;
            peak_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            alert_reg <= alert_next;
            peak_reg  <= peak_next;
            if (state_reg == ST_DONE)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_v_reg    <= sq_v_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        az_reg      <= az_next;
        ssum_reg    <= ssum_next;
        lsum_reg    <= lsum_next;
        zsum_reg    <= zsum_next;
        sta_reg     <= sta_next;
        lta_reg     <= lta_next;
        zsta_reg    <= zsta_next;
        ratio_reg   <= ratio_next;
        rd_addr_reg <= rd_addr_next;
        if (state_reg == ST_DIV_ZR && div_rsp.done)
            sp_hold_reg <= sp_w;
        if (state_reg == ST_DONE)
        begin
            o_sta_reg   <= sta_reg;
            o_lta_reg   <= lta_reg;
            o_ratio_reg <= ratio_reg;
            o_alert_reg <= alert_reg;
            o_q_reg     <= (peak_reg > RATIO_W'(20)) ? 7'd100 :
                           (peak_reg > RATIO_W'(15)) ? mid_pct_reg : 7'd0;
            o_s_reg     <= alert_reg ? sp_hold_reg : 7'd0;
            o_p_reg     <= alert_reg ? 7'd100 - sp_hold_reg : 7'd0;
        end
    end

    assign in_ch.ready           = (state_reg == ST_IDLE) && (rsp_reg == 2'b00);
    assign out_ch.valid          = ov_reg;
    assign out_ch.short_avg      = o_sta_reg;
    assign out_ch.long_avg       = o_lta_reg;
    assign out_ch.trigger_ratio  = o_ratio_reg;
    assign out_ch.alert_active   = o_alert_reg;
    assign out_ch.quake_percent  = o_q_reg;
    assign out_ch.p_wave_percent = o_p_reg;
    assign out_ch.s_wave_percent = o_s_reg;
endmodule

// File: rtl/slq_checker.sv
// ---------------------------------------------------------------------------
// slq_checker
// Port-level checks of the quake trigger unit.
// ---------------------------------------------------------------------------
`include "sta_lta_quake_trigger_unit_assert.svh"
module slq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        alert_active,
    input logic [6:0]  p_wave_percent,
    input logic [6:0]  s_wave_percent
);
    `SLQ_ASSERT_IMPL(a_no_ready_with_result, clk, rst_n, out_valid, !in_ready)
    `SLQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `SLQ_ASSERT_IMPL(a_waves_off, clk, rst_n, out_valid && !alert_active,
        p_wave_percent == 7'd0 && s_wave_percent == 7'd0)
    `SLQ_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind sta_lta_quake_trigger_unit slq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .alert_active(out_ch.alert_active), .p_wave_percent(out_ch.p_wave_percent),
    .s_wave_percent(out_ch.s_wave_percent)
);
